@@ sv/ccl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccl_pkg: shared types and constants of the clock command line parser
// Character codes, command and parse phase codes, result kinds and the
// BCD conversion used to build the alarm word.
// ----------------------------------------------------------------------------
package ccl_pkg;

	localparam int LINE_LIMIT_DEF = 19;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UP_T  = 8'h54;
	localparam logic [7:0] CH_LO_T  = 8'h74;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_LO_A  = 8'h61;

	localparam logic [6:0]  NUM_MAX    = 7'd99;
	localparam logic [31:0] ALARM_MASK = 32'h8000_0000;

	typedef enum logic [1:0] {
		CMD_NONE  = 2'd0,
		CMD_TIME  = 2'd1,
		CMD_ALARM = 2'd2,
		CMD_OTHER = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		PH_NUM0 = 3'd0,
		PH_NUM1 = 3'd1,
		PH_NUM2 = 3'd2,
		PH_DONE = 3'd3,
		PH_FAIL = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		KIND_TIME    = 2'd0,
		KIND_ALARM   = 2'd1,
		KIND_INVALID = 2'd2
	} kind_t;

	// Two BCD digits of a value below 100; tens by reciprocal multiply.
	function automatic logic [7:0] to_bcd(input logic [6:0] v);
		logic [14:0] prod;
		logic [3:0]  tens;
		logic [6:0]  ones;
		prod = 15'(v) * 15'd205;
		tens = prod[14:11];
		ones = v - 7'(tens) * 7'd10;
		return {tens, ones[3:0]};
	endfunction

endpackage
`default_nettype wire

@@ sv/ccl_rx_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccl_rx_if: received character channel
// Valid/ready channel that moves one ASCII character per word.
// ----------------------------------------------------------------------------
interface ccl_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

@@ sv/ccl_res_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccl_res_if: parsed command channel
// Valid/ready channel that moves one parsed command line per word.
// ----------------------------------------------------------------------------
interface ccl_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  result_kind;
	logic [6:0]  hours;
	logic [6:0]  minutes;
	logic [6:0]  seconds;
	logic [31:0] alarm_word;

	modport source (output valid, output result_kind, output hours, output minutes,
		output seconds, output alarm_word, input ready);
	modport sink   (input valid, input result_kind, input hours, input minutes,
		input seconds, input alarm_word, output ready);
endinterface
`default_nettype wire

@@ sv/clock_command_line_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clock_command_line_parser: line parser for clock time-sync and alarm commands
// Assembles received characters into lines and emits one word per command.
// ----------------------------------------------------------------------------
// The parser takes one character word per clock cycle, sustained, on rx and
// emits at most one word on res for each CR or LF that closes a non-empty
// line. A character is registered in the input register on acceptance and
// folded into the line state by a single-character update when that register
// advances; a line end that gives a result loads the output register at that
// same edge, so a result passes the input and then the output register. The
// output register lets rx keep flowing while a result waits; rx stalls only
// when a line end that gives a result sits in the input register while the
// previous result is still not taken. Lines
// starting with T/t are time sync (kind 0), A/a alarm set (kind 1), anything
// else invalid (kind 2, all numbers zero). T and A lines need "hh:mm:ss",
// blanks allowed before each number, trailing text ignored; numbers saturate
// at 99 and a line that does not parse gives no word. Only the first
// LINE_LIMIT characters of a line are looked at.
// ----------------------------------------------------------------------------
module clock_command_line_parser #(
	parameter int LINE_LIMIT = ccl_pkg::LINE_LIMIT_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	ccl_rx_if.sink     rx,
	ccl_res_if.source  res
);

	localparam int CNT_W = $clog2(LINE_LIMIT + 1);

	// input stage
	logic       valid_s1;
	logic [7:0] rx_s1;

	// line state
	logic [CNT_W-1:0]     cnt_q;
	ccl_pkg::cmd_t        cmd_q;
	ccl_pkg::phase_t      phase_q;
	logic                 digit_q;
	logic [6:0]           num_q [3];

	// output register
	logic                 out_valid_q;
	ccl_pkg::kind_t       kind_q;
	logic [6:0]           hours_q;
	logic [6:0]           minutes_q;
	logic [6:0]           seconds_q;
	logic [31:0]          alarm_q;

	// next-state and result logic
	logic                 is_eol;
	logic                 is_digit;
	logic                 is_blank;
	logic                 parse_ok;
	logic                 emit;
	logic                 s1_move;
	logic                 s1_fire;
	logic [CNT_W-1:0]     cnt_d;
	ccl_pkg::cmd_t        cmd_d;
	ccl_pkg::phase_t      phase_d;
	logic                 digit_d;
	logic [6:0]           num_d [3];
	logic [1:0]           num_idx;
	logic [9:0]           num_ext;
	ccl_pkg::kind_t       kind_d;
	logic [31:0]          alarm_d;

	assign is_eol   = (rx_s1 == ccl_pkg::CH_CR) || (rx_s1 == ccl_pkg::CH_LF);
	assign is_digit = (rx_s1 >= ccl_pkg::CH_ZERO) && (rx_s1 <= ccl_pkg::CH_NINE);
	assign is_blank = (rx_s1 == ccl_pkg::CH_SPACE) || (rx_s1 == ccl_pkg::CH_TAB) ||
		(rx_s1 == ccl_pkg::CH_VT) || (rx_s1 == ccl_pkg::CH_FF);
	assign num_idx  = phase_q[1:0];
	// grow the current number by one decimal digit
	assign num_ext  = 10'(num_q[num_idx]) * 10'd10 + 10'(rx_s1[3:0]);

	// a T/A line is good once the third number is closed or still has digits
	assign parse_ok = (phase_q == ccl_pkg::PH_DONE) ||
		((phase_q == ccl_pkg::PH_NUM2) && digit_q);
	assign emit     = valid_s1 && is_eol && (cnt_q != '0) &&
		((cmd_q == ccl_pkg::CMD_OTHER) || parse_ok);

	// advance the input stage unless a result must wait for a full output
	assign s1_move  = !emit || !out_valid_q || res.ready;
	assign s1_fire  = valid_s1 && s1_move;
	assign rx.ready = !valid_s1 || s1_move;

	always_comb begin
		cnt_d   = cnt_q;
		cmd_d   = cmd_q;
		phase_d = phase_q;
		digit_d = digit_q;
		num_d   = num_q;
		if (is_eol) begin
			// close the line and start clean
			cnt_d   = '0;
			cmd_d   = ccl_pkg::CMD_NONE;
			phase_d = ccl_pkg::PH_NUM0;
			digit_d = 1'b0;
			num_d   = '{default: 7'd0};
		end else if (cnt_q < CNT_W'(LINE_LIMIT)) begin
			cnt_d = cnt_q + 1'b1;
			if (cnt_q == '0) begin
				if ((rx_s1 == ccl_pkg::CH_UP_T) || (rx_s1 == ccl_pkg::CH_LO_T)) begin
					cmd_d = ccl_pkg::CMD_TIME;
				end else if ((rx_s1 == ccl_pkg::CH_UP_A) ||
						(rx_s1 == ccl_pkg::CH_LO_A)) begin
					cmd_d = ccl_pkg::CMD_ALARM;
				end else begin
					cmd_d = ccl_pkg::CMD_OTHER;
				end
			end else if ((phase_q == ccl_pkg::PH_NUM0) || (phase_q == ccl_pkg::PH_NUM1) ||
					(phase_q == ccl_pkg::PH_NUM2)) begin
				if (is_digit) begin
					num_d[num_idx] = (num_ext > 10'(ccl_pkg::NUM_MAX)) ?
						ccl_pkg::NUM_MAX : num_ext[6:0];
					digit_d = 1'b1;
				end else if (!digit_q) begin
					if (!is_blank) begin
						phase_d = ccl_pkg::PH_FAIL;
					end
				end else if (phase_q == ccl_pkg::PH_NUM2) begin
					phase_d = ccl_pkg::PH_DONE;
				end else if (rx_s1 == ccl_pkg::CH_COLON) begin
					phase_d = (phase_q == ccl_pkg::PH_NUM0) ?
						ccl_pkg::PH_NUM1 : ccl_pkg::PH_NUM2;
					digit_d = 1'b0;
				end else begin
					phase_d = ccl_pkg::PH_FAIL;
				end
			end
		end
	end

	always_comb begin
		case (cmd_q)
			ccl_pkg::CMD_ALARM: kind_d = ccl_pkg::KIND_ALARM;
			ccl_pkg::CMD_TIME:  kind_d = ccl_pkg::KIND_TIME;
			default:            kind_d = ccl_pkg::KIND_INVALID;
		endcase
		alarm_d = ccl_pkg::ALARM_MASK | {8'd0, ccl_pkg::to_bcd(num_q[0]),
			ccl_pkg::to_bcd(num_q[1]), ccl_pkg::to_bcd(num_q[2])};
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			rx_s1 <= rx.rx_byte;
		end
	end

	// line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			cmd_q   <= ccl_pkg::CMD_NONE;
			phase_q <= ccl_pkg::PH_NUM0;
			digit_q <= 1'b0;
			num_q   <= '{default: 7'd0};
		end else if (s1_fire) begin
			cnt_q   <= cnt_d;
			cmd_q   <= cmd_d;
			phase_q <= phase_d;
			digit_q <= digit_d;
			num_q   <= num_d;
		end
	end

	// output register: hold until taken, load on a line end that emits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && emit) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && emit) begin
			kind_q <= kind_d;
			if (cmd_q == ccl_pkg::CMD_OTHER) begin
				hours_q   <= 7'd0;
				minutes_q <= 7'd0;
				seconds_q <= 7'd0;
			end else begin
				hours_q   <= num_q[0];
				minutes_q <= num_q[1];
				seconds_q <= num_q[2];
			end
			alarm_q <= (cmd_q == ccl_pkg::CMD_ALARM) ? alarm_d : 32'd0;
		end
	end

	assign res.valid       = out_valid_q;
	assign res.result_kind = kind_q;
	assign res.hours       = hours_q;
	assign res.minutes     = minutes_q;
	assign res.seconds     = seconds_q;
	assign res.alarm_word  = alarm_q;

	// ------------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------------
	a_cnt_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(LINE_LIMIT))
		else $error("line character count beyond limit");

	a_eol_clears: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && is_eol |=> cnt_q == '0 && phase_q == ccl_pkg::PH_NUM0)
		else $error("line state not cleared after line end");

	a_alarm_mask: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q == ccl_pkg::KIND_ALARM |-> alarm_q[31])
		else $error("alarm word without mask bit");

	a_num_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> hours_q <= ccl_pkg::NUM_MAX && minutes_q <= ccl_pkg::NUM_MAX &&
			seconds_q <= ccl_pkg::NUM_MAX)
		else $error("parsed number above saturation");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res.ready |-> !(s1_fire && emit))
		else $error("pending result overwritten");

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the clock command line parser
// Streams character words into the parser with bursty timing, stalls the
// result side on a changing pattern, predicts every parsed command line in
// step with the accepted characters and checks each result word in order.
// ----------------------------------------------------------------------------
module testbench;
	import ccl_pkg::*;

	localparam int LINE_CAP     = LINE_LIMIT_DEF;
	localparam int RANDOM_CHARS = 320;
	localparam int QUIET_LIMIT  = 4000;  // cycles with no word moving on either side
	localparam int DRAIN_CYCLES = 20;    // extra wait after every predicted word is seen

	// Receiver behavior, switched after each random stretch.
	typedef enum logic [1:0] {
		SINK_OPEN,
		SINK_RANDOM,
		SINK_CHOKED
	} sink_mode_t;

	typedef struct {
		kind_t       kind;
		logic [6:0]  hours;
		logic [6:0]  minutes;
		logic [6:0]  seconds;
		logic [31:0] alarm_word;
	} line_result_t;

	logic clk;
	logic arst_n;

	ccl_rx_if  rx_ch ();
	ccl_res_if res_ch ();

	clock_command_line_parser #(
		.LINE_LIMIT(LINE_CAP)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx_ch),
		.res(res_ch)
	);

	// Characters still to be sent, head is the one on the wire.
	logic [7:0]   tx_chars[$];
	// Parsed lines predicted but not yet seen on the result channel.
	line_result_t due_results[$];
	bit           any_failure = 1'b0;

	// Shadow of the line state.
	int     line_len   = 0;
	cmd_t   line_cmd   = CMD_NONE;
	phase_t line_phase = PH_NUM0;
	bit     digit_open = 1'b0;
	int     nums[3]    = '{0, 0, 0};

	// Driver and receiver bookkeeping.
	bit         took       = 1'b0;
	int         burst_left = 1;
	int         gap_left   = 0;
	sink_mode_t sink_mode  = SINK_OPEN;
	int         sink_left  = 0;
	int         quiet      = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [7:0] two_digit_bcd(input int v);
		return {4'(v / 10), 4'(v % 10)};
	endfunction

	// Fold one accepted character into the shadow line state; on a line end
	// push the word the parser must emit, if any, and start a fresh line.
	task automatic advance_line(input logic [7:0] ch);
		line_result_t r;
		int           idx;
		int           acc;
		if (ch == CH_CR || ch == CH_LF) begin
			if (line_len > 0) begin
				if (line_cmd == CMD_OTHER) begin
					r.kind       = KIND_INVALID;
					r.hours      = '0;
					r.minutes    = '0;
					r.seconds    = '0;
					r.alarm_word = '0;
					due_results.push_back(r);
				end else if (line_phase == PH_DONE || (line_phase == PH_NUM2 && digit_open)) begin
					r.hours   = 7'(nums[0]);
					r.minutes = 7'(nums[1]);
					r.seconds = 7'(nums[2]);
					if (line_cmd == CMD_ALARM) begin
						r.kind       = KIND_ALARM;
						r.alarm_word = ALARM_MASK | {8'h00, two_digit_bcd(nums[0]),
							two_digit_bcd(nums[1]), two_digit_bcd(nums[2])};
					end else begin
						r.kind       = KIND_TIME;
						r.alarm_word = '0;
					end
					due_results.push_back(r);
				end
			end
			line_len   = 0;
			line_cmd   = CMD_NONE;
			line_phase = PH_NUM0;
			digit_open = 1'b0;
			nums       = '{0, 0, 0};
			return;
		end
		// Past the cap the character is dropped without a trace.
		if (line_len >= LINE_CAP)
			return;
		if (line_len == 0) begin
			if (ch == CH_UP_T || ch == CH_LO_T)
				line_cmd = CMD_TIME;
			else if (ch == CH_UP_A || ch == CH_LO_A)
				line_cmd = CMD_ALARM;
			else
				line_cmd = CMD_OTHER;
		end else if (line_phase != PH_DONE && line_phase != PH_FAIL) begin
			idx = int'(line_phase);
			if (ch >= CH_ZERO && ch <= CH_NINE) begin
				acc       = nums[idx] * 10 + int'(ch - CH_ZERO);
				nums[idx] = (acc > int'(NUM_MAX)) ? int'(NUM_MAX) : acc;
				digit_open = 1'b1;
			end else if (!digit_open) begin
				// Blanks may lead a number; anything else (signs too) kills the line.
				if (!(ch == CH_SPACE || ch == CH_TAB || ch == CH_VT || ch == CH_FF))
					line_phase = PH_FAIL;
			end else if (line_phase == PH_NUM2) begin
				line_phase = PH_DONE;  // trailing text after the seconds is ignored
			end else if (ch == CH_COLON) begin
				line_phase = phase_t'(line_phase + 3'd1);
				digit_open = 1'b0;
			end else begin
				line_phase = PH_FAIL;
			end
		end
		line_len++;
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			tx_chars.push_back(s[i]);
	endtask

	// One random line: mostly well-formed "hh:mm:ss" commands with random
	// blanks, digit counts and trailing text, some with a corrupted byte;
	// the rest is raw noise or a line with some other first letter.
	task automatic add_random_line();
		logic [7:0] ln[$];
		int         reps;
		if ($urandom_range(0, 9) == 0) begin
			reps = $urandom_range(0, 24);
			repeat (reps) ln.push_back(8'($urandom_range(0, 255)));
		end else begin
			case ($urandom_range(0, 4))
				0: ln.push_back(CH_UP_T);
				1: ln.push_back(CH_LO_T);
				2: ln.push_back(CH_UP_A);
				3: ln.push_back(CH_LO_A);
				default: ln.push_back(8'($urandom_range(32, 126)));
			endcase
			for (int n = 0; n < 3; n++) begin
				reps = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
				repeat (reps) begin
					case ($urandom_range(0, 3))
						0: ln.push_back(CH_SPACE);
						1: ln.push_back(CH_TAB);
						2: ln.push_back(CH_VT);
						default: ln.push_back(CH_FF);
					endcase
				end
				// Now and then a missing number, otherwise one to three digits.
				reps = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 3);
				repeat (reps) ln.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
				if (n < 2)
					ln.push_back(CH_COLON);
			end
			reps = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
			repeat (reps) ln.push_back(8'($urandom_range(32, 126)));
			if ($urandom_range(0, 4) == 0)
				ln[$urandom_range(0, ln.size() - 1)] = 8'($urandom_range(0, 255));
		end
		ln.push_back(($urandom_range(0, 1) == 0) ? CH_CR : CH_LF);
		// An occasional extra terminator makes an empty line.
		if ($urandom_range(0, 9) == 0)
			ln.push_back(CH_LF);
		foreach (ln[i])
			tx_chars.push_back(ln[i]);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			any_failure = 1'b1;
		end
	endtask

	// Driver: change inputs on the falling edge. Hold a word until it is
	// taken; after each burst of accepted words insert a random gap.
	always @(negedge clk) begin
		if (!arst_n) begin
			rx_ch.valid <= 1'b0;
		end else begin
			if (took) begin
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
			if (!(rx_ch.valid && !took)) begin
				if (gap_left > 0) begin
					gap_left--;
					rx_ch.valid <= 1'b0;
				end else if (tx_chars.size() != 0) begin
					rx_ch.valid   <= 1'b1;
					rx_ch.rx_byte <= tx_chars[0];
				end else begin
					rx_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: open, random or choked, each for a random stretch.
	always @(negedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (sink_left == 0) begin
				sink_mode = sink_mode_t'($urandom_range(0, 2));
				sink_left = $urandom_range(16, 80);
			end
			sink_left--;
			case (sink_mode)
				SINK_OPEN:   res_ch.ready <= 1'b1;
				SINK_RANDOM: res_ch.ready <= 1'($urandom_range(0, 1));
				default:     res_ch.ready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	// Monitor: on each rising edge advance the prediction with an accepted
	// character, then check an accepted result word against the oldest one due.
	always @(posedge clk) begin
		took = 1'b0;
		if (arst_n) begin
			if (rx_ch.valid && rx_ch.ready) begin
				took = 1'b1;
				advance_line(rx_ch.rx_byte);
				void'(tx_chars.pop_front());
			end
			if (res_ch.valid && res_ch.ready) begin
				if (due_results.size() == 0) begin
					$error("result word with none due: kind %0d", res_ch.result_kind);
					any_failure = 1'b1;
				end else begin
					check_field("result_kind", 32'(due_results[0].kind), 32'(res_ch.result_kind));
					check_field("hours", 32'(due_results[0].hours), 32'(res_ch.hours));
					check_field("minutes", 32'(due_results[0].minutes), 32'(res_ch.minutes));
					check_field("seconds", 32'(due_results[0].seconds), 32'(res_ch.seconds));
					check_field("alarm_word", due_results[0].alarm_word, res_ch.alarm_word);
					void'(due_results.pop_front());
				end
			end
		end
	end

	// Watchdog: end the run if no word moves on either side for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("clock_command_line_parser verification failed");
				$finish;
			end
		end
	end

	initial begin
		arst_n         = 1'b0;
		rx_ch.valid    = 1'b0;
		rx_ch.rx_byte  = '0;
		res_ch.ready   = 1'b0;

		// Directed lines: plain and lowercase commands, blanks of every kind
		// before the numbers, trailing text, zeros and saturation.
		push_text("T12:34:56");
		tx_chars.push_back(CH_CR);
		push_text("a ");
		tx_chars.push_back(CH_TAB);
		push_text("7:");
		tx_chars.push_back(CH_VT);
		push_text("8:");
		tx_chars.push_back(CH_FF);
		push_text("9 junk");
		tx_chars.push_back(CH_LF);
		push_text("A00:00:00");
		tx_chars.push_back(CH_LF);
		push_text("t123:456:789");
		tx_chars.push_back(CH_CR);
		push_text("A99:99:99");
		// CR then LF: the LF closes an empty line and must give nothing.
		tx_chars.push_back(CH_CR);
		tx_chars.push_back(CH_LF);
		// Invalid first letters, a NUL and an all-ones byte among them.
		push_text("X9:9:9");
		tx_chars.push_back(CH_LF);
		tx_chars.push_back(8'h00);
		tx_chars.push_back(CH_LF);
		tx_chars.push_back(8'hFF);
		tx_chars.push_back(CH_CR);
		// Parse failures: sign, bad separator, missing digits, NUL in a number.
		push_text("T+1:2:3");
		tx_chars.push_back(CH_LF);
		push_text("T1;2:3");
		tx_chars.push_back(CH_LF);
		push_text("A:2:3");
		tx_chars.push_back(CH_LF);
		push_text("a1:2:");
		tx_chars.push_back(CH_CR);
		push_text("T1:2");
		tx_chars.push_back(8'h00);
		push_text("3");
		tx_chars.push_back(CH_LF);
		// Long lines: characters past the cap are dropped, so in the first the seconds never start.
		push_text("T1:2:                7");
		tx_chars.push_back(CH_LF);
		push_text("A1:2:3456789012345678901");
		tx_chars.push_back(CH_CR);
		push_text("Zzzzzzzzzzzzzzzzzzzzzzzzz");
		tx_chars.push_back(CH_LF);

		begin
			int target;
			target = tx_chars.size() + RANDOM_CHARS;
			while (tx_chars.size() < target)
				add_random_line();
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Drain: every character taken and every predicted word seen.
		while (tx_chars.size() != 0 || due_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (!any_failure)
			$display("clock_command_line_parser verification clean");
		else
			$display("clock_command_line_parser verification failed");
		$finish;
	end

endmodule
